@@ hw/rtl/lswr_pkg.sv @@
// Shared widths, opcodes and status codes of the LIFO stack with reverse.
package lswr_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 5;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned DepthDef = 16;

  localparam logic [CountW-1:0] CapacityRst = CountW'(16);

  localparam logic [OpW-1:0] OpPush    = 2'd0;
  localparam logic [OpW-1:0] OpPop     = 2'd1;
  localparam logic [OpW-1:0] OpPeek    = 2'd2;
  localparam logic [OpW-1:0] OpReverse = 2'd3;

  localparam logic [StatusW-1:0] StatOk    = 2'd0;
  localparam logic [StatusW-1:0] StatFull  = 2'd1;
  localparam logic [StatusW-1:0] StatEmpty = 2'd2;

endpackage

@@ hw/rtl/lswr_if.sv @@
// Valid/ready channel interfaces: operation in, result out, capacity write.
interface lswr_in_if;
  logic                                valid;
  logic                                ready;
  logic        [lswr_pkg::OpW-1:0]     opcode;
  logic signed [lswr_pkg::DataW-1:0]   push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface lswr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lswr_pkg::DataW-1:0]   data;
  logic        [lswr_pkg::StatusW-1:0] status;
  logic        [lswr_pkg::CountW-1:0]  count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink   (input valid, input data, input status, input count, output ready);
endinterface

interface lswr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lswr_pkg::CountW-1:0]        data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/lifo_stack_with_reverse_core.sv @@
// Top level of the bounded LIFO stack with in-place reverse.
//
//   channel  dir  beat contents                   handshake
//   in_i     in   opcode, push_value              valid/ready
//   out_o    out  data, status, count             valid/ready
//   cfg_i    in   data (capacity)                 valid/ready, ready tied high
//
// Push loads the result register directly; pop and peek go through one registered memory read (state Read) first.
// Reverse walks the pairs from both ends inward: one write port, two writes per pair (states SwapLo, SwapHi).
// rst_ni clears count, capacity (to 16) and the result valid flag; the entry store and result data are not cleared.
// One item at a time; the next beat is taken once the result register is free or draining.
module lifo_stack_with_reverse_core import lswr_pkg::*; #(
  parameter int unsigned Depth = DepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lswr_in_if.sink    in_i,
  lswr_out_if.source out_o,
  lswr_cfg_if.sink   cfg_i
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr_a;
  logic [AddrW-1:0] mem_raddr_b;
  logic [DataW-1:0] mem_rdata_a;
  logic [DataW-1:0] mem_rdata_b;

  lswr_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_o         (out_o),
    .cfg_i         (cfg_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  lswr_mem #(
    .Depth(Depth)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule

@@ hw/rtl/lswr_mem.sv @@
// Entry store: one write port, two registered read ports.
module lswr_mem import lswr_pkg::*; #(
  parameter int unsigned Depth = DepthDef
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [DataW-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_a_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_b_i,
  output logic [DataW-1:0]                          rdata_a_o,
  output logic [DataW-1:0]                          rdata_b_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_a_q;
  logic [DataW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ hw/rtl/lswr_ctrl.sv @@
// Sequencer: count, capacity, memory accesses, reverse swap walk, result register.
module lswr_ctrl import lswr_pkg::*; #(
  parameter int unsigned Depth = DepthDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  lswr_in_if.sink                                   in_i,
  lswr_out_if.source                                out_o,
  lswr_cfg_if.sink                                  cfg_i,
  output logic                                      mem_we_o,
  output logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] mem_waddr_o,
  output logic [DataW-1:0]                          mem_wdata_o,
  output logic                                      mem_re_o,
  output logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] mem_raddr_a_o,
  output logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] mem_raddr_b_o,
  input  logic [DataW-1:0]                          mem_rdata_a_i,
  input  logic [DataW-1:0]                          mem_rdata_b_i
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [1:0] StateIdle   = 2'd0;
  localparam logic [1:0] StateRead   = 2'd1;
  localparam logic [1:0] StateSwapLo = 2'd2;
  localparam logic [1:0] StateSwapHi = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  lo_q, lo_d;
  logic [CountW-1:0]  hi_q, hi_d;
  logic [CountW-1:0]  cap_q;

  logic               out_valid_q;
  logic [DataW-1:0]   out_data_q;
  logic [StatusW-1:0] out_status_q;
  logic [CountW-1:0]  out_count_q;

  logic               res_load;
  logic [DataW-1:0]   res_data;
  logic [StatusW-1:0] res_status;

  logic in_fire;
  logic out_fire;
  logic is_full;
  logic is_empty;

  assign in_i.ready = (state_q == StateIdle) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;
  assign cfg_i.ready = 1'b1;

  // effective limit is min(capacity, Depth)
  assign is_full  = (count_q >= cap_q) || (32'(count_q) >= 32'(Depth));
  assign is_empty = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityRst;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.data;
    end
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = '0;
    mem_wdata_o   = '0;
    mem_re_o      = 1'b0;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;
    res_load      = 1'b0;
    res_data      = '0;
    res_status    = StatOk;
    unique case (state_q)
      StateIdle: begin
        if (in_fire) begin
          unique case (in_i.opcode)
            OpPush: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status = StatFull;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AddrW'(count_q);
                mem_wdata_o = in_i.push_value;
                count_d     = count_q + 1'b1;
              end
            end
            OpPop, OpPeek: begin
              if (is_empty) begin
                res_load   = 1'b1;
                res_status = StatEmpty;
              end else begin
                mem_re_o      = 1'b1;
                mem_raddr_a_o = AddrW'(count_q - 1'b1);
                if (in_i.opcode == OpPop) begin
                  count_d = count_q - 1'b1;
                end
                state_d = StateRead;
              end
            end
            default: begin
              if (count_q < CountW'(2)) begin
                res_load = 1'b1;
              end else begin
                // fetch both ends of the first pair
                mem_re_o      = 1'b1;
                mem_raddr_a_o = '0;
                mem_raddr_b_o = AddrW'(count_q - 1'b1);
                lo_d          = '0;
                hi_d          = count_q - 1'b1;
                state_d       = StateSwapLo;
              end
            end
          endcase
        end
      end
      StateRead: begin
        res_load = 1'b1;
        res_data = mem_rdata_a_i;
        state_d  = StateIdle;
      end
      StateSwapLo: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(lo_q);
        mem_wdata_o = mem_rdata_b_i;
        state_d     = StateSwapHi;
      end
      default: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(hi_q);
        mem_wdata_o = mem_rdata_a_i;
        // next pair read overlaps the write; addresses differ from hi_q
        if ((lo_q + 1'b1) < (hi_q - 1'b1)) begin
          lo_d          = lo_q + 1'b1;
          hi_d          = hi_q - 1'b1;
          mem_re_o      = 1'b1;
          mem_raddr_a_o = AddrW'(lo_q + 1'b1);
          mem_raddr_b_o = AddrW'(hi_q - 1'b1);
          state_d       = StateSwapLo;
        end else begin
          res_load = 1'b1;
          state_d  = StateIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q   <= res_data;
      out_status_q <= res_status;
      out_count_q  <= count_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.data   = out_data_q;
  assign out_o.status = out_status_q;
  assign out_o.count  = out_count_q;

endmodule

@@ dv/tb_top.sv @@
// Testbench of the LIFO stack with reverse: queued operations, stack predictor, result checks.
`timescale 1ns / 1ps

module tb_top;
  import lswr_pkg::*;

  localparam int unsigned Depth      = DepthDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseOps   = 160;

  typedef struct {
    logic [OpW-1:0]          opcode;
    logic signed [DataW-1:0] value;
  } stack_op_t;

  typedef struct {
    logic signed [DataW-1:0] data;
    logic [StatusW-1:0]      status;
    logic [CountW-1:0]       count;
  } stack_result_t;

  logic clk;
  logic rst_n;

  lswr_in_if  in_if ();
  lswr_out_if out_if ();
  lswr_cfg_if cfg_if ();

  lifo_stack_with_reverse_core #(
    .Depth(Depth)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  stack_op_t     op_queue[$];
  stack_result_t result_queue[$];

  // predictor state
  logic signed [DataW-1:0] entries[Depth];
  int unsigned             held     = 0;
  logic [CountW-1:0]       capacity = CapacityRst;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count    = 0;
  int unsigned cycles        = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic stack_result_t stack_apply(logic [OpW-1:0] op,
                                                logic signed [DataW-1:0] val);
    stack_result_t           res;
    int unsigned             lim;
    int                      lo;
    int                      hi;
    logic signed [DataW-1:0] tmp;
    res.data   = '0;
    res.status = StatOk;
    lim = (capacity > Depth) ? Depth : capacity;
    case (op)
      OpPush: begin
        if (held >= lim) begin
          res.status = StatFull;
        end else begin
          entries[held] = val;
          held++;
        end
      end
      OpPop: begin
        if (held == 0) begin
          res.status = StatEmpty;
        end else begin
          held--;
          res.data = entries[held];
        end
      end
      OpPeek: begin
        if (held == 0) res.status = StatEmpty;
        else res.data = entries[held-1];
      end
      default: begin
        lo = 0;
        hi = int'(held) - 1;
        while (lo < hi) begin
          tmp         = entries[lo];
          entries[lo] = entries[hi];
          entries[hi] = tmp;
          lo++;
          hi--;
        end
      end
    endcase
    res.count = held[CountW-1:0];
    return res;
  endfunction

  // driver: one beat per free slot, expectation taken at acceptance
  always @(posedge clk) begin
    stack_op_t nxt;
    if (in_if.valid && in_if.ready) begin
      result_queue.push_back(stack_apply(in_if.opcode, in_if.push_value));
    end
    if (cfg_if.valid && cfg_if.ready) capacity = cfg_if.data;
    if (!in_if.valid || in_if.ready) begin
      if (rst_n && op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = op_queue.pop_front();
        in_if.valid      <= 1'b1;
        in_if.opcode     <= nxt.opcode;
        in_if.push_value <= nxt.value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stack_result_t exp_res;
    if (out_if.valid && out_if.ready) begin
      if (result_queue.size() == 0) begin
        $error("result beat with nothing expected: data %0d status %0d count %0d",
               out_if.data, out_if.status, out_if.count);
        fail_count++;
      end else begin
        exp_res = result_queue.pop_front();
        if (out_if.data !== exp_res.data) begin
          $error("data: expected %0d, got %0d", exp_res.data, out_if.data);
          fail_count++;
        end
        if (out_if.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_if.status);
          fail_count++;
        end
        if (out_if.count !== exp_res.count) begin
          $error("count: expected %0d, got %0d", exp_res.count, out_if.count);
          fail_count++;
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic queue_op(logic [OpW-1:0] op, logic signed [DataW-1:0] val);
    stack_op_t item;
    item.opcode = op;
    item.value  = val;
    op_queue.push_back(item);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (op_queue.size() != 0 || in_if.valid || result_queue.size() != 0);
  endtask

  task automatic write_capacity(logic [CountW-1:0] cap);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cap;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // bursts lean toward filling, draining or mixing so full and empty both get hit
  task automatic run_random(int unsigned n);
    int unsigned             burst;
    int unsigned             push_pct;
    int unsigned             r;
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] val;
    while (n > 0) begin
      burst = $urandom_range(24, 4);
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 45;
      endcase
      for (int unsigned i = 0; i < burst && n > 0; i++) begin
        r = $urandom_range(99);
        if (r < push_pct) begin
          op = OpPush;
        end else begin
          r = $urandom_range(9);
          op = (r < 5) ? OpPop : (r < 8) ? OpPeek : OpReverse;
        end
        case ($urandom_range(9))
          0:       val = 32'sh7fff_ffff;
          1:       val = 32'sh8000_0000;
          2:       val = '0;
          3:       val = -1;
          default: val = $urandom();
        endcase
        queue_op(op, val);
        n--;
      end
    end
  endtask

  initial begin
    logic [CountW-1:0] caps[10];
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd16, 5'd9, 5'd3};

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OpPush;
    in_if.push_value = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 84;

    // empty stack, single entry, extremes, reverse of a few entries
    queue_op(OpPop, 32'sd5);
    queue_op(OpPeek, 32'sd6);
    queue_op(OpReverse, 32'sd7);
    queue_op(OpPush, 32'sh7fff_ffff);
    queue_op(OpReverse, '0);
    queue_op(OpPeek, '0);
    queue_op(OpPush, 32'sh8000_0000);
    queue_op(OpPush, '0);
    queue_op(OpPush, -1);
    queue_op(OpReverse, '0);
    queue_op(OpPeek, '0);
    queue_op(OpPop, '0);
    queue_op(OpPop, '0);
    queue_op(OpPop, '0);
    queue_op(OpPop, '0);
    wait_drained();

    // capacity of one: second push refused
    write_capacity(5'd1);
    queue_op(OpPush, 32'sh5555_5555);
    queue_op(OpPush, 32'shaaaa_aaaa);
    queue_op(OpReverse, '0);
    queue_op(OpPop, '0);
    wait_drained();

    // capacity zero counts as full
    write_capacity(5'd0);
    queue_op(OpPush, 32'sh1234_5678);
    queue_op(OpPeek, '0);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      if (p < 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 84;
      end else if (p < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(caps[p]);
      run_random(PhaseOps);
      wait_drained();
    end

    // reverse can hold the block busy for its whole swap walk
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
